// File: rtl/text_line_numbering_escape_filter_macros.svh
// Assertion helpers shared by the filter modules.
`ifndef TEXT_LINE_NUMBERING_ESCAPE_FILTER_MACROS_SVH
`define TEXT_LINE_NUMBERING_ESCAPE_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLNEF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLNEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tlnef_pkg.sv
package tlnef_pkg;

  // Line counter size in BCD digits
  localparam int COUNT_DIGITS = 8;
  localparam int MIN_NUM_WIDTH = 6;
  localparam int DIG_IDX_W = $clog2(COUNT_DIGITS);
  localparam int SIG_W = $clog2(COUNT_DIGITS + 1);

  // Configuration port
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NUMBER_EVERY    = 3'd0,
    CFG_NUMBER_NONEMPTY = 3'd1,
    CFG_SQUEEZE_EMPTY   = 3'd2,
    CFG_MARK_ENDS       = 3'd3,
    CFG_MARK_TABS       = 3'd4,
    CFG_MARK_NONPRINT   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_NUM,
    ST_TAB,
    ST_REND
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic emit_num;
    logic emit_tab;
    logic emit_rend;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic drop;
    logic do_num;
    logic num_done;
    logic rend_done;
    logic out_free;
  } status_t;

endpackage

// File: rtl/tlnef_ctrl.sv
module tlnef_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tlnef_pkg::status_t status,
  output tlnef_pkg::cmd_t    cmd
);

  tlnef_pkg::state_t state_r, state_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tlnef_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (status.drop) state_nxt = tlnef_pkg::ST_IDLE;
          else if (status.do_num) state_nxt = tlnef_pkg::ST_NUM;
          else state_nxt = tlnef_pkg::ST_REND;
        end
      end
      tlnef_pkg::ST_NUM: begin
        if (status.out_free && status.num_done) state_nxt = tlnef_pkg::ST_TAB;
      end
      tlnef_pkg::ST_TAB: begin
        if (status.out_free) state_nxt = tlnef_pkg::ST_REND;
      end
      tlnef_pkg::ST_REND: begin
        if (status.out_free && status.rend_done) state_nxt = tlnef_pkg::ST_IDLE;
      end
      default: state_nxt = tlnef_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      tlnef_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.accept = in_valid;
      end
      tlnef_pkg::ST_NUM:  cmd.emit_num = status.out_free;
      tlnef_pkg::ST_TAB:  cmd.emit_tab = status.out_free;
      tlnef_pkg::ST_REND: cmd.emit_rend = status.out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tlnef_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`include "text_line_numbering_escape_filter_macros.svh"

  `TLNEF_ASSERT_NEXT(a_num_follows, cmd.accept && !status.drop && status.do_num,
                     state_r == tlnef_pkg::ST_NUM, "numbered line did not start with its number")
  `TLNEF_ASSERT_NEXT(a_drop_stays_idle, cmd.accept && status.drop,
                     state_r == tlnef_pkg::ST_IDLE, "squeezed newline produced output work")
  `TLNEF_ASSERT_NOW(a_one_emit, state_r == tlnef_pkg::ST_IDLE,
                    !cmd.emit_num && !cmd.emit_tab && !cmd.emit_rend, "emit while idle")

endmodule

// File: rtl/tlnef_dp.sv
module tlnef_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [tlnef_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tlnef_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [7:0]                           in_byte,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic [7:0]                           out_byte,
  output logic                                 out_last_of_run,
  input  tlnef_pkg::cmd_t                      cmd,
  output tlnef_pkg::status_t                   status
);

  localparam int CD = tlnef_pkg::COUNT_DIGITS;
  localparam int SIGW_LOCAL = tlnef_pkg::SIG_W;

  // Configuration bits
  logic number_every_r, number_nonempty_r, squeeze_r;
  logic mark_ends_r, mark_tabs_r, mark_np_r;

  // Line state
  logic [CD-1:0][3:0] count_r, count_nxt;
  logic               seen_empty_r, at_start_r;

  // Number and rendering sequencing
  logic [tlnef_pkg::SIG_W-1:0]     sig_r, sig_nxt;
  logic [tlnef_pkg::DIG_IDX_W-1:0] pos_r, pos_nxt;
  logic [3:0][7:0]                 rend_r, rend_nxt;
  logic [1:0]                      rend_idx_r, rend_last_r, rend_last_nxt;

  // Output register
  logic       out_valid_r;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       emit;

  logic is_nl, drop, do_num;

  // Line-start decisions for the byte on offer
  always_comb begin
    is_nl  = (in_byte == 8'h0A);
    drop   = at_start_r && squeeze_r && is_nl && seen_empty_r;
    do_num = at_start_r && !drop && (number_every_r || (number_nonempty_r && !is_nl));
  end

  // Saturating BCD increment and significant digit count of the result
  always_comb begin
    logic carry;
    logic [SIGW_LOCAL-1:0] width;
    carry = 1'b1;
    count_nxt = count_r;
    for (int i = 0; i < CD; i++) begin
      if (carry) begin
        if (count_r[i] >= 4'd9) begin
          count_nxt[i] = 4'd0;
        end else begin
          count_nxt[i] = count_r[i] + 4'd1;
          carry = 1'b0;
        end
      end
    end
    if (carry) count_nxt = count_r;
    sig_nxt = tlnef_pkg::SIG_W'(1);
    for (int i = 0; i < CD; i++) begin
      if (count_nxt[i] != 4'd0) sig_nxt = tlnef_pkg::SIG_W'(i + 1);
    end
    if (sig_nxt < tlnef_pkg::SIG_W'(tlnef_pkg::MIN_NUM_WIDTH))
      width = SIGW_LOCAL'(tlnef_pkg::MIN_NUM_WIDTH);
    else
      width = SIGW_LOCAL'(sig_nxt);
    pos_nxt = tlnef_pkg::DIG_IDX_W'(width - SIGW_LOCAL'(1));
  end

  // Render the byte into up to four output bytes
  always_comb begin
    logic [7:0] x;
    x = {1'b0, in_byte[6:0]};
    rend_nxt = {4{in_byte}};
    rend_last_nxt = 2'd0;
    priority if (mark_tabs_r && in_byte == 8'h09) begin
      rend_nxt[0] = "^";
      rend_nxt[1] = "I";
      rend_last_nxt = 2'd1;
    end else if (mark_np_r && in_byte < 8'd32 && in_byte != 8'h09 && !is_nl) begin
      rend_nxt[0] = "^";
      rend_nxt[1] = in_byte + 8'd64;
      rend_last_nxt = 2'd1;
    end else if (mark_np_r && in_byte == 8'h7F) begin
      rend_nxt[0] = "^";
      rend_nxt[1] = "?";
      rend_last_nxt = 2'd1;
    end else if (mark_np_r && in_byte[7]) begin
      rend_nxt[0] = "M";
      rend_nxt[1] = "-";
      priority if (x < 8'd32) begin
        rend_nxt[2] = "^";
        rend_nxt[3] = x + 8'd64;
        rend_last_nxt = 2'd3;
      end else if (x == 8'h7F) begin
        rend_nxt[2] = "^";
        rend_nxt[3] = "?";
        rend_last_nxt = 2'd3;
      end else begin
        rend_nxt[2] = x;
        rend_last_nxt = 2'd2;
      end
    end else if (is_nl) begin
      if (mark_ends_r) begin
        rend_nxt[0] = "$";
        rend_nxt[1] = 8'h0A;
        rend_last_nxt = 2'd1;
      end else begin
        rend_nxt[0] = 8'h0A;
      end
    end else begin
      rend_nxt[0] = in_byte;
    end
  end

  // Select the next output byte
  always_comb begin
    emit = cmd.emit_num || cmd.emit_tab || cmd.emit_rend;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;
    priority if (cmd.emit_num) begin
      if (SIGW_LOCAL'(pos_r) >= sig_r) out_byte_nxt = " ";
      else out_byte_nxt = 8'h30 | {4'h0, count_r[pos_r]};
      out_last_nxt = 1'b0;
    end else if (cmd.emit_tab) begin
      out_byte_nxt = 8'h09;
      out_last_nxt = 1'b0;
    end else if (cmd.emit_rend) begin
      out_byte_nxt = rend_r[rend_idx_r];
      out_last_nxt = (rend_idx_r == rend_last_r);
    end else begin
      // Hold the current byte
      out_byte_nxt = out_byte_r;
      out_last_nxt = out_last_r;
    end
  end

  always_comb begin
    status.drop      = drop;
    status.do_num    = do_num;
    status.num_done  = (pos_r == '0);
    status.rend_done = (rend_idx_r == rend_last_r);
    status.out_free  = !out_valid_r || out_ready;
  end

  // Control state: configuration, line state, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      number_every_r    <= 1'b0;
      number_nonempty_r <= 1'b0;
      squeeze_r         <= 1'b0;
      mark_ends_r       <= 1'b0;
      mark_tabs_r       <= 1'b0;
      mark_np_r         <= 1'b0;
      count_r           <= '0;
      seen_empty_r      <= 1'b0;
      at_start_r        <= 1'b1;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tlnef_pkg::CFG_NUMBER_EVERY:    number_every_r    <= cfg_data[0];
          tlnef_pkg::CFG_NUMBER_NONEMPTY: number_nonempty_r <= cfg_data[0];
          tlnef_pkg::CFG_SQUEEZE_EMPTY:   squeeze_r         <= cfg_data[0];
          tlnef_pkg::CFG_MARK_ENDS:       mark_ends_r       <= cfg_data[0];
          tlnef_pkg::CFG_MARK_TABS:       mark_tabs_r       <= cfg_data[0];
          tlnef_pkg::CFG_MARK_NONPRINT:   mark_np_r         <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        if (at_start_r && squeeze_r) seen_empty_r <= is_nl;
        if (do_num) count_r <= count_nxt;
        at_start_r <= is_nl;
      end
      if (emit) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload: sequencing registers and output byte
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rend_r      <= rend_nxt;
      rend_last_r <= rend_last_nxt;
      rend_idx_r  <= 2'd0;
      sig_r       <= sig_nxt;
      pos_r       <= pos_nxt;
    end else begin
      if (cmd.emit_num && pos_r != '0) pos_r <= pos_r - tlnef_pkg::DIG_IDX_W'(1);
      if (cmd.emit_rend) rend_idx_r <= rend_idx_r + 2'd1;
    end
    if (emit) begin
      out_byte_r <= out_byte_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

`include "text_line_numbering_escape_filter_macros.svh"

  `TLNEF_ASSERT_NOW(a_no_overwrite, emit, !out_valid_r || out_ready,
                    "output byte overwritten before transfer")
  `TLNEF_ASSERT_NEXT(a_tab_not_last, cmd.emit_tab, !out_last_r && out_valid_r,
                     "number tab flagged as last byte")
  `TLNEF_ASSERT_NEXT(a_drop_keeps_line_start, cmd.accept && drop, at_start_r && seen_empty_r,
                     "squeezed newline left line start")

endmodule

// File: rtl/text_line_numbering_escape_filter.sv
// Cat-style text filter: one byte in, zero to COUNT_DIGITS+5 bytes out, at most one
// output byte per cycle. An input byte is accepted in the idle state, then its output
// bytes leave at one per cycle while the consumer keeps up: one or two for most bytes,
// up to four for M- forms, plus max(6, digits)+1 for a numbered line start. The next
// byte is taken once the previous byte's last output sits in the output register. A
// squeezed empty line gives no output and no last_of_run marker. The line counter is
// BCD and holds at all nines.
module text_line_numbering_escape_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tlnef_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlnef_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_last_of_run
);

  tlnef_pkg::cmd_t    cmd;
  tlnef_pkg::status_t status;

  // Sequencer
  tlnef_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Counter, renderer and output register
  tlnef_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_byte        (in_byte),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_byte       (out_byte),
    .out_last_of_run(out_last_of_run),
    .cmd            (cmd),
    .status         (status)
  );

endmodule
